[rtl/cph_pkg.sv]
package cph_pkg;

   localparam int SLOTS        = 8;
   localparam int WORD_W       = 64;
   localparam int FIELD_W      = 8;
   localparam int CNT_W        = 4;
   localparam int PEN_W        = 16;
   localparam int EST_W        = 25;
   localparam int T_FRAC       = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int SLOT_IDX_W   = 3;

   localparam int MAX_WAYPOINTS_DEF = 8;
   localparam int COORD_BITS_DEF    = 8;

   localparam logic [EST_W-1:0] EST_MAX     = '1;
   localparam logic [PEN_W-1:0] PENALTY_RST = 16'd768;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GOAL_X         = 3'd0,
      CSR_GOAL_Y         = 3'd1,
      CSR_WAYPOINT_COUNT = 3'd2,
      CSR_PENALTY        = 3'd3,
      CSR_WAYPOINTS_LOW  = 3'd4,
      CSR_WAYPOINTS_HIGH = 3'd5
   } csr_index_type;

   // per-operation tags that ride alongside each segment job
   typedef struct packed {
      logic first;
      logic last;
      logic none;
   } flags_type;

   // pick the packed x/y pair of one waypoint slot
   function automatic logic [15:0] waypoint_pick(input logic [WORD_W-1:0] lo,
                                                  input logic [WORD_W-1:0] hi,
                                                  input logic [SLOT_IDX_W-1:0] idx);
      logic [WORD_W-1:0] word;
      word = idx[2] ? hi : lo;
      return word[{idx[1:0], 4'b0000} +: 16];
   endfunction

endpackage

[rtl/cph_div_pipe.sv]
module cph_div_pipe #(
   parameter int NW    = 18,
   parameter int QB    = 16,
   parameter int PAY_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             vld_i,
   input  logic [NW-1:0]    num_i,
   input  logic [NW-1:0]    den_i,
   input  logic [PAY_W-1:0] pay_i,
   output logic             vld_o,
   output logic [QB-1:0]    quo_o,
   output logic [PAY_W-1:0] pay_o
);

   logic             vld_ff [QB];
   logic [NW-1:0]    rem_ff [QB];
   logic [NW-1:0]    den_ff [QB];
   logic [QB-1:0]    quo_ff [QB];
   logic [PAY_W-1:0] pay_ff [QB];

   // one quotient bit per stage, restoring form
   for (genvar s = 0; s < QB; s++) begin : g_stage
      logic             vld_src;
      logic [NW-1:0]    rem_src;
      logic [NW-1:0]    den_src;
      logic [QB-1:0]    quo_src;
      logic [PAY_W-1:0] pay_src;
      logic [NW:0]      shifted;
      logic             take;

      if (s == 0) begin : g_head
         assign vld_src = vld_i;
         assign rem_src = num_i;
         assign den_src = den_i;
         assign quo_src = '0;
         assign pay_src = pay_i;
      end else begin : g_body
         assign vld_src = vld_ff[s-1];
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign quo_src = quo_ff[s-1];
         assign pay_src = pay_ff[s-1];
      end

      assign shifted = {rem_src, 1'b0};
      assign take    = shifted >= {1'b0, den_src};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= take ? NW'(shifted - {1'b0, den_src}) : NW'(shifted);
            den_ff[s] <= den_src;
            quo_ff[s] <= {quo_src[QB-2:0], take};
            pay_ff[s] <= pay_src;
         end
      end
   end

   assign vld_o = vld_ff[QB-1];
   assign quo_o = quo_ff[QB-1];
   assign pay_o = pay_ff[QB-1];

endmodule

[rtl/cph_isqrt_pipe.sv]
module cph_isqrt_pipe #(
   parameter int LANES = 2,
   parameter int RW    = 33,
   parameter int QW    = 17,
   parameter int TAG_W = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       vld_i,
   input  logic [LANES-1:0][RW-1:0]   rad_i,
   input  logic [TAG_W-1:0]           tag_i,
   output logic                       vld_o,
   output logic [LANES-1:0][QW-1:0]   root_o,
   output logic [TAG_W-1:0]           tag_o
);

   localparam int TW = RW + 2;

   logic                     vld_ff  [QW];
   logic [TAG_W-1:0]         tag_ff  [QW];
   logic [LANES-1:0][RW-1:0] rem_ff  [QW];
   logic [LANES-1:0][QW-1:0] root_ff [QW];

   // one root bit per stage, most significant first
   for (genvar s = 0; s < QW; s++) begin : g_stage
      localparam int B = QW - 1 - s;

      logic                     vld_src;
      logic [TAG_W-1:0]         tag_src;
      logic [LANES-1:0][RW-1:0] rem_src;
      logic [LANES-1:0][QW-1:0] root_src;
      logic [LANES-1:0][RW-1:0] rem_nx;
      logic [LANES-1:0][QW-1:0] root_nx;

      if (s == 0) begin : g_head
         assign vld_src  = vld_i;
         assign tag_src  = tag_i;
         assign rem_src  = rad_i;
         assign root_src = '0;
      end else begin : g_body
         assign vld_src  = vld_ff[s-1];
         assign tag_src  = tag_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [TW-1:0] term;
         logic          take;
         assign term = (TW'(root_src[l]) << (B + 1)) + (TW'(1) << (2 * B));
         assign take = TW'(rem_src[l]) >= term;
         assign rem_nx[l]  = take ? RW'(TW'(rem_src[l]) - term) : rem_src[l];
         assign root_nx[l] = take ? (root_src[l] | (QW'(1) << B)) : root_src[l];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[s]  <= tag_src;
            rem_ff[s]  <= rem_nx;
            root_ff[s] <= root_nx;
         end
      end
   end

   assign vld_o  = vld_ff[QW-1];
   assign root_o = root_ff[QW-1];
   assign tag_o  = tag_ff[QW-1];

endmodule

[rtl/corridor_polyline_heuristic.sv]
// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_ready   req_cell_x, req_cell_y
// rsp      out        rsp_valid / rsp_ready   rsp_estimate, rsp_saturated
// csr      in         csr_valid / csr_ready   csr_index, csr_data
//
// A transaction on req issues one job per polyline segment into a pipelined
// segment-distance unit, one job per cycle unless rsp stalls: n-1 jobs per cell, n being
// the waypoint count clamped to min(MAX_WAYPOINTS, 8) (one job when there is no segment).
// Each job passes through, among others, the 16-stage divider and the COORD_BITS+9 root
// stages. Reset is synchronous; it clears the valid and busy flags and resets the CSR
// registers, but not the datapath registers. A stall on rsp freezes the whole pipeline
// in place; nothing is dropped.
module corridor_polyline_heuristic #(
   parameter int MAX_WAYPOINTS = cph_pkg::MAX_WAYPOINTS_DEF,
   parameter int COORD_BITS    = cph_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [cph_pkg::FIELD_W-1:0]    req_cell_x,
   input  logic [cph_pkg::FIELD_W-1:0]    req_cell_y,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [cph_pkg::EST_W-1:0]      rsp_estimate,
   output logic                           rsp_saturated,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cph_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cph_pkg::WORD_W-1:0]     csr_data
);

   localparam int CW  = COORD_BITS;
   localparam int VW  = CW + 1;          // signed coordinate difference
   localparam int DW  = 2 * CW + 3;      // signed dot / squared length
   localparam int NW  = 2 * CW + 2;      // divider operand
   localparam int RW  = 2 * CW + 17;     // root radicand
   localparam int QW  = CW + 9;          // root result, Q.8
   localparam int EW  = CW + 19;         // signed offset, Q.16
   localparam int MW  = CW + 16;         // offset magnitude
   localparam int XW  = 2 * MW;          // squared offset
   localparam int SQW = XW + 1;
   localparam int TW  = cph_pkg::T_FRAC + 1;
   localparam int PW  = cph_pkg::PEN_W + QW;
   localparam int SW  = (PW - 7 > cph_pkg::EST_W + 1) ? PW - 7 : cph_pkg::EST_W + 1;
   localparam int LIMIT = (MAX_WAYPOINTS < cph_pkg::SLOTS) ? MAX_WAYPOINTS : cph_pkg::SLOTS;
   localparam int SIW = cph_pkg::SLOT_IDX_W;
   localparam logic [7:0] BYTE_MASK = (CW >= 8) ? 8'hFF : 8'((1 << CW) - 1);

   typedef struct packed {
      cph_pkg::flags_type     fl;
      logic signed [VW-1:0]   vx;
      logic signed [VW-1:0]   vy;
      logic signed [VW-1:0]   wx;
      logic signed [VW-1:0]   wy;
      logic [RW-1:0]          grad;
      logic                   tzero;
      logic                   tone;
   } dpay_type;

   localparam int PAY_W = $bits(dpay_type);

   // ---------------------------------------------------------------- registers
   logic [7:0]                      goal_x_ff, goal_x_in;
   logic [7:0]                      goal_y_ff, goal_y_in;
   logic [cph_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [cph_pkg::PEN_W-1:0]       penalty_ff, penalty_in;
   logic [cph_pkg::WORD_W-1:0]      wlow_ff, wlow_in;
   logic [cph_pkg::WORD_W-1:0]      whigh_ff, whigh_in;

   assign csr_ready = 1'b1;

   always_comb begin
      goal_x_in  = goal_x_ff;
      goal_y_in  = goal_y_ff;
      count_in   = count_ff;
      penalty_in = penalty_ff;
      wlow_in    = wlow_ff;
      whigh_in   = whigh_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cph_pkg::CSR_GOAL_X:         goal_x_in  = csr_data[7:0];
            cph_pkg::CSR_GOAL_Y:         goal_y_in  = csr_data[7:0];
            cph_pkg::CSR_WAYPOINT_COUNT: count_in   = csr_data[cph_pkg::CNT_W-1:0];
            cph_pkg::CSR_PENALTY:        penalty_in = csr_data[cph_pkg::PEN_W-1:0];
            cph_pkg::CSR_WAYPOINTS_LOW:  wlow_in    = csr_data;
            cph_pkg::CSR_WAYPOINTS_HIGH: whigh_in   = csr_data;
            default: ;  // unknown index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff  <= '0;
         goal_y_ff  <= '0;
         count_ff   <= '0;
         penalty_ff <= cph_pkg::PENALTY_RST;
         wlow_ff    <= '0;
         whigh_ff   <= '0;
      end else begin
         goal_x_ff  <= goal_x_in;
         goal_y_ff  <= goal_y_in;
         count_ff   <= count_in;
         penalty_ff <= penalty_in;
         wlow_ff    <= wlow_in;
         whigh_ff   <= whigh_in;
      end
   end

   // ---------------------------------------------------------------- pipeline advance
   // The whole pipeline moves together; it holds while the output register is full
   // and not taken.
   logic adv;
   logic rsp_valid_ff;
   assign adv = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------- issue sequencer
   logic                   busy_ff, busy_in;
   logic [SIW-1:0]         seg_ff, seg_in;
   logic [SIW-1:0]         lastseg_ff, lastseg_in;
   logic                   none_ff, none_in;
   logic [CW-1:0]          px_ff, px_in;
   logic [CW-1:0]          py_ff, py_in;
   logic                   op_last;
   logic                   accept;
   logic [cph_pkg::CNT_W-1:0] n_eff;

   assign n_eff     = (count_ff > cph_pkg::CNT_W'(LIMIT)) ? cph_pkg::CNT_W'(LIMIT) : count_ff;
   assign op_last   = none_ff || (seg_ff == lastseg_ff);
   assign req_ready = !busy_ff || (adv && op_last);
   assign accept    = req_valid && req_ready;

   always_comb begin
      busy_in    = busy_ff;
      seg_in     = seg_ff;
      lastseg_in = lastseg_ff;
      none_in    = none_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      if (busy_ff && adv) begin
         seg_in = seg_ff + SIW'(1);
         if (op_last) begin
            busy_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in    = 1'b1;
         seg_in     = '0;
         none_in    = n_eff < cph_pkg::CNT_W'(2);
         lastseg_in = SIW'(n_eff - cph_pkg::CNT_W'(2));
         px_in      = CW'(req_cell_x & BYTE_MASK);
         py_in      = CW'(req_cell_y & BYTE_MASK);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff     <= seg_in;
      lastseg_ff <= lastseg_in;
      none_ff    <= none_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
   end

   // ---------------------------------------------------------------- stage 0: endpoints
   logic [15:0]          wa, wb;
   logic [CW-1:0]        ax, ay, bx, by, gx, gy;

   assign wa = cph_pkg::waypoint_pick(wlow_ff, whigh_ff, seg_ff);
   assign wb = cph_pkg::waypoint_pick(wlow_ff, whigh_ff, seg_ff + SIW'(1));
   assign ax = CW'(wa[7:0] & BYTE_MASK);
   assign ay = CW'(wa[15:8] & BYTE_MASK);
   assign bx = CW'(wb[7:0] & BYTE_MASK);
   assign by = CW'(wb[15:8] & BYTE_MASK);
   assign gx = CW'(goal_x_ff & BYTE_MASK);
   assign gy = CW'(goal_y_ff & BYTE_MASK);

   logic                 p0_vld_ff;
   cph_pkg::flags_type   p0_fl_ff;
   logic signed [VW-1:0] p0_vx_ff, p0_vy_ff, p0_wx_ff, p0_wy_ff, p0_gx_ff, p0_gy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_vld_ff <= 1'b0;
      end else if (adv) begin
         p0_vld_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_fl_ff <= '{first: (seg_ff == '0), last: op_last, none: none_ff};
         p0_vx_ff <= $signed({1'b0, bx}) - $signed({1'b0, ax});
         p0_vy_ff <= $signed({1'b0, by}) - $signed({1'b0, ay});
         p0_wx_ff <= $signed({1'b0, px_ff}) - $signed({1'b0, ax});
         p0_wy_ff <= $signed({1'b0, py_ff}) - $signed({1'b0, ay});
         p0_gx_ff <= $signed({1'b0, px_ff}) - $signed({1'b0, gx});
         p0_gy_ff <= $signed({1'b0, py_ff}) - $signed({1'b0, gy});
      end
   end

   // ---------------------------------------------------------------- stage 1: products
   logic signed [DW-1:0] vxe, vye, wxe, wye, gxe, gye, gsum;
   assign vxe  = DW'(p0_vx_ff);
   assign vye  = DW'(p0_vy_ff);
   assign wxe  = DW'(p0_wx_ff);
   assign wye  = DW'(p0_wy_ff);
   assign gxe  = DW'(p0_gx_ff);
   assign gye  = DW'(p0_gy_ff);
   assign gsum = gxe * gxe + gye * gye;

   logic                 p1_vld_ff;
   cph_pkg::flags_type   p1_fl_ff;
   logic signed [DW-1:0] p1_len2_ff, p1_dot_ff;
   logic signed [VW-1:0] p1_vx_ff, p1_vy_ff, p1_wx_ff, p1_wy_ff;
   logic [RW-1:0]        p1_grad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff <= p0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_fl_ff   <= p0_fl_ff;
         p1_len2_ff <= vxe * vxe + vye * vye;
         p1_dot_ff  <= wxe * vxe + wye * vye;
         p1_vx_ff   <= p0_vx_ff;
         p1_vy_ff   <= p0_vy_ff;
         p1_wx_ff   <= p0_wx_ff;
         p1_wy_ff   <= p0_wy_ff;
         p1_grad_ff <= RW'($unsigned(gsum)) << cph_pkg::T_FRAC;
      end
   end

   // ---------------------------------------------------------------- stage 2: clamp of t
   logic          p2_vld_ff;
   dpay_type      p2_pay_ff;
   logic [NW-1:0] p2_num_ff, p2_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else if (adv) begin
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_pay_ff.fl    <= p1_fl_ff;
         p2_pay_ff.vx    <= p1_vx_ff;
         p2_pay_ff.vy    <= p1_vy_ff;
         p2_pay_ff.wx    <= p1_wx_ff;
         p2_pay_ff.wy    <= p1_wy_ff;
         p2_pay_ff.grad  <= p1_grad_ff;
         p2_pay_ff.tzero <= (p1_len2_ff == '0) || (p1_dot_ff <= 0);
         p2_pay_ff.tone  <= !((p1_len2_ff == '0) || (p1_dot_ff <= 0))
                            && (p1_dot_ff >= p1_len2_ff);
         p2_num_ff       <= NW'(p1_dot_ff);
         p2_den_ff       <= NW'(p1_len2_ff);
      end
   end

   // ---------------------------------------------------------------- divider: t = dot/len2
   logic                          dv_vld;
   logic [cph_pkg::T_FRAC-1:0]    dv_quo;
   logic [PAY_W-1:0]              dv_pay_raw;
   dpay_type                      dv_pay;

   cph_div_pipe #(
      .NW    (NW),
      .QB    (cph_pkg::T_FRAC),
      .PAY_W (PAY_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .en    (adv),
      .vld_i (p2_vld_ff),
      .num_i (p2_num_ff),
      .den_i (p2_den_ff),
      .pay_i (PAY_W'(p2_pay_ff)),
      .vld_o (dv_vld),
      .quo_o (dv_quo),
      .pay_o (dv_pay_raw)
   );

   assign dv_pay = dpay_type'(dv_pay_raw);

   logic [TW-1:0] t_q;
   assign t_q = dv_pay.tzero ? '0 :
                dv_pay.tone  ? (TW'(1) << cph_pkg::T_FRAC) : TW'(dv_quo);

   // ---------------------------------------------------------------- stage 3: offsets
   logic signed [EW-1:0] tse;
   assign tse = EW'($signed({1'b0, t_q}));

   logic                 p3_vld_ff;
   cph_pkg::flags_type   p3_fl_ff;
   logic [RW-1:0]        p3_grad_ff;
   logic signed [EW-1:0] p3_ex_ff, p3_ey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_vld_ff <= 1'b0;
      end else if (adv) begin
         p3_vld_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_fl_ff   <= dv_pay.fl;
         p3_grad_ff <= dv_pay.grad;
         p3_ex_ff   <= (EW'(dv_pay.wx) <<< cph_pkg::T_FRAC) - tse * EW'(dv_pay.vx);
         p3_ey_ff   <= (EW'(dv_pay.wy) <<< cph_pkg::T_FRAC) - tse * EW'(dv_pay.vy);
      end
   end

   // ---------------------------------------------------------------- stage 4: squares
   logic [MW-1:0] exm, eym;
   assign exm = MW'(p3_ex_ff[EW-1] ? -p3_ex_ff : p3_ex_ff);
   assign eym = MW'(p3_ey_ff[EW-1] ? -p3_ey_ff : p3_ey_ff);

   logic               p4_vld_ff;
   cph_pkg::flags_type p4_fl_ff;
   logic [RW-1:0]      p4_grad_ff;
   logic [XW-1:0]      p4_exsq_ff, p4_eysq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_vld_ff <= 1'b0;
      end else if (adv) begin
         p4_vld_ff <= p3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p4_fl_ff   <= p3_fl_ff;
         p4_grad_ff <= p3_grad_ff;
         p4_exsq_ff <= XW'(exm) * XW'(exm);
         p4_eysq_ff <= XW'(eym) * XW'(eym);
      end
   end

   // ---------------------------------------------------------------- stage 5: radicand
   // floor(sqrt(s)) >> 8 equals floor(sqrt(s >> 16)): drop the fraction first.
   logic [SQW-1:0] sqsum;
   assign sqsum = SQW'(p4_exsq_ff) + SQW'(p4_eysq_ff);

   logic               p5_vld_ff;
   cph_pkg::flags_type p5_fl_ff;
   logic [RW-1:0]      p5_grad_ff, p5_rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_vld_ff <= 1'b0;
      end else if (adv) begin
         p5_vld_ff <= p4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p5_fl_ff   <= p4_fl_ff;
         p5_grad_ff <= p4_grad_ff;
         p5_rad_ff  <= RW'(sqsum >> cph_pkg::T_FRAC);
      end
   end

   // ---------------------------------------------------------------- roots: segment and goal
   logic                   sq_vld;
   logic [1:0][QW-1:0]     sq_root;
   logic [$bits(cph_pkg::flags_type)-1:0] sq_tag;
   cph_pkg::flags_type     sq_fl;

   cph_isqrt_pipe #(
      .LANES (2),
      .RW    (RW),
      .QW    (QW),
      .TAG_W ($bits(cph_pkg::flags_type))
   ) u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .vld_i  (p5_vld_ff),
      .rad_i  ({p5_grad_ff, p5_rad_ff}),
      .tag_i  (p5_fl_ff),
      .vld_o  (sq_vld),
      .root_o (sq_root),
      .tag_o  (sq_tag)
   );

   assign sq_fl = cph_pkg::flags_type'(sq_tag);

   // ---------------------------------------------------------------- stage 6: running minimum
   logic [QW-1:0] best_ff, best_in;
   assign best_in = (sq_fl.first || (sq_root[0] < best_ff)) ? sq_root[0] : best_ff;

   logic          p6_vld_ff;
   logic          p6_none_ff;
   logic [QW-1:0] p6_best_ff, p6_goal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p6_vld_ff <= 1'b0;
      end else if (adv) begin
         p6_vld_ff <= sq_vld && sq_fl.last;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (sq_vld) begin
            best_ff <= best_in;
         end
         p6_none_ff <= sq_fl.none;
         p6_best_ff <= best_in;
         p6_goal_ff <= sq_root[1];
      end
   end

   // ---------------------------------------------------------------- stage 7: weighting
   logic          p7_vld_ff;
   logic          p7_none_ff;
   logic [PW-1:0] p7_prod_ff;
   logic [QW-1:0] p7_goal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p7_vld_ff <= 1'b0;
      end else if (adv) begin
         p7_vld_ff <= p6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p7_none_ff <= p6_none_ff;
         p7_goal_ff <= p6_goal_ff;
         p7_prod_ff <= PW'(penalty_ff) * PW'(p6_best_ff);
      end
   end

   // ---------------------------------------------------------------- output register
   logic [SW-1:0]              total;
   logic                       sat;
   logic [cph_pkg::EST_W-1:0]  rsp_estimate_ff;
   logic                       rsp_saturated_ff;

   assign total = SW'(p7_goal_ff) + SW'(p7_prod_ff >> 8);
   assign sat   = p7_none_ff || (total > SW'(cph_pkg::EST_MAX));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= p7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_estimate_ff  <= sat ? cph_pkg::EST_MAX : cph_pkg::EST_W'(total);
         rsp_saturated_ff <= sat;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_estimate  = rsp_estimate_ff;
   assign rsp_saturated = rsp_saturated_ff;

`ifndef ASSERT_OFF
   // an accepted cell always leaves the sequencer with work to issue
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("accepted cell did not start issuing");

   // the segment counter never runs past the final segment of a cell
   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !none_ff) |-> (seg_ff <= lastseg_ff))
      else $error("segment index beyond last segment");

   // a held output freezes the pipeline front and back
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(p0_vld_ff) && $stable(p7_vld_ff) && $stable(best_ff)))
      else $error("pipeline moved during a stall");

   // a saturated result always carries the clipped maximum
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_saturated_ff) |-> (rsp_estimate_ff == cph_pkg::EST_MAX))
      else $error("saturated result without maximum estimate");
`endif

endmodule
